@@ hw/rtl/bdlp_pkg.sv @@
// Shared types and constants for the button debounce / long press queue block.
`timescale 1ns / 1ps

package bdlp_pkg;

    localparam int BUTTONS_DEF     = 5;
    localparam int QUEUE_DEPTH_DEF = 8;

    localparam int RAW_BITS = 5;
    localparam int CODE_W   = 3;
    localparam int FILL_W   = 4;
    localparam int DROP_W   = 3;
    localparam int ADDR_W   = 4;
    localparam int DATA_W   = 32;

    localparam logic [1:0] OP_INIT   = 2'd0;
    localparam logic [1:0] OP_SAMPLE = 2'd1;
    localparam logic [1:0] OP_POLL   = 2'd2;

    localparam logic [1:0] REG_DEBOUNCE   = 2'd0;
    localparam logic [1:0] REG_LONG_PRESS = 2'd1;
    localparam logic [1:0] REG_LONG_EN    = 2'd2;

    localparam logic [15:0] DEBOUNCE_RST   = 16'd20;
    localparam logic [15:0] LONG_PRESS_RST = 16'd800;
    localparam logic        LONG_EN_RST    = 1'b1;

    typedef struct packed {
        logic capture;
        logic init;
        logic sample;
        logic poll;
        logic load_out;
    } t_cmd;

    typedef struct packed {
        logic btn_last;
    } t_status;

    typedef struct packed {
        logic [15:0] debounce_ms;
        logic [15:0] hold_ms;
        logic        long_en;
    } t_cfg;

endpackage

@@ hw/rtl/button_debounce_long_press_queue.sv @@
// Top level: configuration registers, sequencer and datapath of the button debouncer.
`timescale 1ns / 1ps

// Debounces BUTTONS buttons against a wrapping millisecond stamp and queues press
// events in a QUEUE_DEPTH-entry FIFO that drops on overflow. One item is worked on
// at a time. After acceptance, init and poll pass through their own state, the
// unused operation goes straight to the done state, and sample walks the buttons
// one per cycle through a single shared compare and update path that owns the only
// queue write port. The next item can be taken in the cycle after a result loads.
// A new item is accepted while a result still waits in the output register, but
// its own result holds until the waiting one is taken. The user writes registers
// over the APB port only while the block is idle; the block does not enforce it.

module button_debounce_long_press_queue #(
    parameter int BUTTONS     = bdlp_pkg::BUTTONS_DEF,
    parameter int QUEUE_DEPTH = bdlp_pkg::QUEUE_DEPTH_DEF
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_in_valid,
    output logic                            o_in_ready,
    input  logic [1:0]                      i_operation,
    input  logic [bdlp_pkg::RAW_BITS-1:0]   i_raw_buttons,
    input  logic [31:0]                     i_now_ms,
    output logic                            o_out_valid,
    input  logic                            i_out_ready,
    output logic [bdlp_pkg::CODE_W-1:0]     o_event_code,
    output logic [bdlp_pkg::RAW_BITS-1:0]   o_held_at_init,
    output logic [bdlp_pkg::RAW_BITS-1:0]   o_stable_mask,
    output logic [bdlp_pkg::FILL_W-1:0]     o_queue_fill,
    output logic [bdlp_pkg::DROP_W-1:0]     o_dropped_now,
    input  logic                            psel,
    input  logic                            penable,
    input  logic                            pwrite,
    input  logic [bdlp_pkg::ADDR_W-1:0]     paddr,
    input  logic [bdlp_pkg::DATA_W-1:0]     pwdata,
    output logic [bdlp_pkg::DATA_W-1:0]     prdata,
    output logic                            pready
);

    bdlp_pkg::t_cmd    cmd;
    bdlp_pkg::t_status status;
    bdlp_pkg::t_cfg    cfg;

    logic [15:0] r_debounce_ms;
    logic [15:0] r_hold_ms;
    logic        r_long_en;
    logic        cfg_wr;

    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite && pready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_debounce_ms <= bdlp_pkg::DEBOUNCE_RST;
            r_hold_ms     <= bdlp_pkg::LONG_PRESS_RST;
            r_long_en     <= bdlp_pkg::LONG_EN_RST;
        end else if (cfg_wr) begin
            case (paddr[3:2])
                bdlp_pkg::REG_DEBOUNCE:   r_debounce_ms <= pwdata[15:0];
                bdlp_pkg::REG_LONG_PRESS: r_hold_ms     <= pwdata[15:0];
                bdlp_pkg::REG_LONG_EN:    r_long_en     <= pwdata[0];
                default: ;
            endcase
        end
    end

    always_comb begin
        case (paddr[3:2])
            bdlp_pkg::REG_DEBOUNCE:   prdata = {16'b0, r_debounce_ms};
            bdlp_pkg::REG_LONG_PRESS: prdata = {16'b0, r_hold_ms};
            bdlp_pkg::REG_LONG_EN:    prdata = {31'b0, r_long_en};
            default:                  prdata = '0;
        endcase
    end

    assign cfg.debounce_ms = r_debounce_ms;
    assign cfg.hold_ms     = r_hold_ms;
    assign cfg.long_en     = r_long_en;

    bdlp_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .i_operation (i_operation),
        .i_out_ready (i_out_ready),
        .i_status    (status),
        .o_in_ready  (o_in_ready),
        .o_out_valid (o_out_valid),
        .o_cmd       (cmd)
    );

    bdlp_dp #(
        .BUTTONS     (BUTTONS),
        .QUEUE_DEPTH (QUEUE_DEPTH)
    ) u_dp (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cmd          (cmd),
        .i_cfg          (cfg),
        .i_raw_buttons  (i_raw_buttons),
        .i_now_ms       (i_now_ms),
        .o_status       (status),
        .o_event_code   (o_event_code),
        .o_held_at_init (o_held_at_init),
        .o_stable_mask  (o_stable_mask),
        .o_queue_fill   (o_queue_fill),
        .o_dropped_now  (o_dropped_now)
    );

    // busy right after an item is taken
    a_busy_after_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in_valid && o_in_ready) |=> !o_in_ready)
        else $error("item accepted while block still busy");

    // a poll result never reports drops, and a drop never carries an event
    a_code_or_drop: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> (o_event_code == '0 || o_dropped_now == '0))
        else $error("event and drop count in the same item");

    // fill never exceeds the queue depth
    a_fill_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> (int'(o_queue_fill) <= QUEUE_DEPTH))
        else $error("queue fill beyond depth");

    // a fresh result appears only after the datapath finished an item
    a_result_load: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && !$past(o_out_valid) && $past(i_rst_n)) |-> $past(cmd.load_out))
        else $error("result valid without a load");

endmodule

@@ hw/rtl/bdlp_ctrl.sv @@
// Sequencer: item handshake, per-operation steps and output register valid.
`timescale 1ns / 1ps

module bdlp_ctrl (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_in_valid,
    input  logic [1:0]          i_operation,
    input  logic                i_out_ready,
    input  bdlp_pkg::t_status   i_status,
    output logic                o_in_ready,
    output logic                o_out_valid,
    output bdlp_pkg::t_cmd      o_cmd
);

    typedef enum logic [2:0] {
        S_IDLE,
        S_INIT,
        S_SAMPLE,
        S_POLL,
        S_DONE
    } t_state;

    t_state r_state, n_state;
    logic   r_out_valid, n_out_valid;

    always_comb begin
        n_state     = r_state;
        n_out_valid = r_out_valid;
        o_cmd       = '0;
        if (r_out_valid && i_out_ready) begin
            n_out_valid = 1'b0;
        end
        case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    o_cmd.capture = 1'b1;
                    case (i_operation)
                        bdlp_pkg::OP_INIT:   n_state = S_INIT;
                        bdlp_pkg::OP_SAMPLE: n_state = S_SAMPLE;
                        bdlp_pkg::OP_POLL:   n_state = S_POLL;
                        default:             n_state = S_DONE;
                    endcase
                end
            end
            S_INIT: begin
                o_cmd.init = 1'b1;
                n_state    = S_DONE;
            end
            S_SAMPLE: begin
                o_cmd.sample = 1'b1;
                if (i_status.btn_last) begin
                    n_state = S_DONE;
                end
            end
            S_POLL: begin
                o_cmd.poll = 1'b1;
                n_state    = S_DONE;
            end
            S_DONE: begin
                if (!r_out_valid || i_out_ready) begin
                    o_cmd.load_out = 1'b1;
                    n_out_valid    = 1'b1;
                    n_state        = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
        end
    end

    assign o_in_ready  = (r_state == S_IDLE);
    assign o_out_valid = r_out_valid;

endmodule

@@ hw/rtl/bdlp_dp.sv @@
// Datapath: per-button debounce state, shared step logic, event queue, result registers.
`timescale 1ns / 1ps

module bdlp_dp #(
    parameter int BUTTONS     = bdlp_pkg::BUTTONS_DEF,
    parameter int QUEUE_DEPTH = bdlp_pkg::QUEUE_DEPTH_DEF
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  bdlp_pkg::t_cmd                  i_cmd,
    input  bdlp_pkg::t_cfg                  i_cfg,
    input  logic [bdlp_pkg::RAW_BITS-1:0]   i_raw_buttons,
    input  logic [31:0]                     i_now_ms,
    output bdlp_pkg::t_status               o_status,
    output logic [bdlp_pkg::CODE_W-1:0]     o_event_code,
    output logic [bdlp_pkg::RAW_BITS-1:0]   o_held_at_init,
    output logic [bdlp_pkg::RAW_BITS-1:0]   o_stable_mask,
    output logic [bdlp_pkg::FILL_W-1:0]     o_queue_fill,
    output logic [bdlp_pkg::DROP_W-1:0]     o_dropped_now
);

    localparam int BTN_W = (BUTTONS > 1) ? $clog2(BUTTONS) : 1;
    localparam int Q_W   = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);
    localparam int SUM_W = Q_W + 1;
    localparam int CW    = bdlp_pkg::CODE_W;
    localparam int RB    = bdlp_pkg::RAW_BITS;

    localparam logic [BTN_W-1:0] BTN_LAST  = BTN_W'(BUTTONS - 1);
    localparam logic [CNT_W-1:0] QD_CNT    = CNT_W'(QUEUE_DEPTH);
    localparam logic [Q_W-1:0]   HEAD_LAST = Q_W'(QUEUE_DEPTH - 1);
    localparam logic [SUM_W-1:0] QD_SUM    = SUM_W'(QUEUE_DEPTH);
    localparam logic [CW-1:0]    LONG_CODE = CW'(BUTTONS + 1);

    // captured item
    logic [BUTTONS-1:0] r_raw;
    logic [31:0]        r_now;

    // button state
    logic [BUTTONS-1:0] r_raw_lvl;
    logic [BUTTONS-1:0] r_stable;
    logic [BUTTONS-1:0] r_long_done;
    logic [31:0]        r_rct [BUTTONS];
    logic [31:0]        r_pt  [BUTTONS];
    logic [BTN_W-1:0]   r_btn;

    // queue
    logic [CW-1:0]      r_mem [QUEUE_DEPTH];
    logic [CW-1:0]      r_mem_q;
    logic [Q_W-1:0]     r_head;
    logic [CNT_W-1:0]   r_count;

    // per-item results
    logic [bdlp_pkg::DROP_W-1:0] r_drops;
    logic [RB-1:0]               r_held;
    logic                        r_poll_hit;

    logic [BUTTONS+RB-1:0] raw_in_ext;
    logic [BUTTONS+RB-1:0] raw_ext;
    logic [BUTTONS+RB-1:0] stable_ext;

    logic              b_raw, b_lvl, b_stable, b_done, long_mode;
    logic              raw_chg, settle, press, new_sl, new_ld, long_fire, push_short, push;
    logic [31:0]       el_raw, el_pt;
    logic [CW-1:0]     push_code;
    logic              q_full;
    logic [SUM_W-1:0]  tail_sum, tail_wrap;
    logic [Q_W-1:0]    tail, head_next;

    assign raw_in_ext = {BUTTONS'(0), i_raw_buttons};
    assign raw_ext    = {RB'(0), r_raw};
    assign stable_ext = {RB'(0), r_stable};

    always_comb begin
        b_raw      = r_raw[r_btn];
        b_lvl      = r_raw_lvl[r_btn];
        b_stable   = r_stable[r_btn];
        b_done     = r_long_done[r_btn];
        long_mode  = i_cfg.long_en && (r_btn == '0);
        raw_chg    = (b_raw != b_lvl);
        el_raw     = r_now - r_rct[r_btn];
        settle     = !raw_chg && (b_raw != b_stable) && (el_raw >= {16'b0, i_cfg.debounce_ms});
        press      = settle && b_raw;
        new_sl     = settle ? b_raw : b_stable;
        new_ld     = press ? 1'b0 : b_done;
        el_pt      = press ? 32'd0 : (r_now - r_pt[r_btn]);
        long_fire  = !raw_chg && long_mode && new_sl && !new_ld
                     && (el_pt >= {16'b0, i_cfg.hold_ms});
        push_short = settle && (b_raw ? !long_mode : (long_mode && !b_done));
        push       = push_short || long_fire;
        push_code  = long_fire ? LONG_CODE : (CW'(r_btn) + CW'(1));
        q_full     = (r_count == QD_CNT);
        tail_sum   = SUM_W'(r_head) + SUM_W'(r_count);
        tail_wrap  = (tail_sum >= QD_SUM) ? (tail_sum - QD_SUM) : tail_sum;
        tail       = tail_wrap[Q_W-1:0];
        head_next  = (r_head == HEAD_LAST) ? '0 : (r_head + Q_W'(1));
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.capture) begin
            r_raw <= raw_in_ext[BUTTONS-1:0];
            r_now <= i_now_ms;
        end
        if (i_cmd.sample && push && !q_full) begin
            r_mem[tail] <= push_code;
        end
        if (i_cmd.poll) begin
            r_mem_q <= r_mem[r_head];
        end
        if (i_cmd.load_out) begin
            o_event_code   <= r_poll_hit ? r_mem_q : '0;
            o_held_at_init <= r_held;
            o_stable_mask  <= stable_ext[RB-1:0];
            o_queue_fill   <= bdlp_pkg::FILL_W'(r_count);
            o_dropped_now  <= r_drops;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_raw_lvl   <= '0;
            r_stable    <= '0;
            r_long_done <= '0;
            for (int i = 0; i < BUTTONS; i++) begin
                r_rct[i] <= '0;
                r_pt[i]  <= '0;
            end
            r_btn      <= '0;
            r_head     <= '0;
            r_count    <= '0;
            r_drops    <= '0;
            r_held     <= '0;
            r_poll_hit <= 1'b0;
        end else begin
            if (i_cmd.capture) begin
                r_btn      <= '0;
                r_drops    <= '0;
                r_held     <= '0;
                r_poll_hit <= 1'b0;
            end
            if (i_cmd.init) begin
                r_raw_lvl   <= r_raw;
                r_stable    <= r_raw;
                r_long_done <= '1;
                for (int i = 0; i < BUTTONS; i++) begin
                    r_rct[i] <= r_now;
                    r_pt[i]  <= r_now;
                end
                r_held <= raw_ext[RB-1:0];
            end
            if (i_cmd.sample) begin
                r_btn <= r_btn + BTN_W'(1);
                if (raw_chg) begin
                    r_raw_lvl[r_btn] <= b_raw;
                    r_rct[r_btn]     <= r_now;
                end else begin
                    r_stable[r_btn]    <= new_sl;
                    r_long_done[r_btn] <= long_fire ? 1'b1 : new_ld;
                    if (press) begin
                        r_pt[r_btn] <= r_now;
                    end
                end
                if (push) begin
                    if (q_full) begin
                        r_drops <= r_drops + bdlp_pkg::DROP_W'(1);
                    end else begin
                        r_count <= r_count + CNT_W'(1);
                    end
                end
            end
            if (i_cmd.poll) begin
                r_poll_hit <= (r_count != '0);
                if (r_count != '0) begin
                    r_head  <= head_next;
                    r_count <= r_count - CNT_W'(1);
                end
            end
        end
    end

    assign o_status.btn_last = (r_btn == BTN_LAST);

endmodule

@@ tb/bdlp_event_checker.sv @@
// Result checker for the button debouncer: tracks config writes, predicts and compares results.
`timescale 1ns / 1ps

module bdlp_event_checker (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_in_valid,
    input  logic                          i_in_ready,
    input  logic [1:0]                    i_operation,
    input  logic [bdlp_pkg::RAW_BITS-1:0] i_raw_buttons,
    input  logic [31:0]                   i_now_ms,
    input  logic                          i_out_valid,
    input  logic                          i_out_ready,
    input  logic [bdlp_pkg::CODE_W-1:0]   i_event_code,
    input  logic [bdlp_pkg::RAW_BITS-1:0] i_held_at_init,
    input  logic [bdlp_pkg::RAW_BITS-1:0] i_stable_mask,
    input  logic [bdlp_pkg::FILL_W-1:0]   i_queue_fill,
    input  logic [bdlp_pkg::DROP_W-1:0]   i_dropped_now,
    input  logic                          psel,
    input  logic                          penable,
    input  logic                          pwrite,
    input  logic [bdlp_pkg::ADDR_W-1:0]   paddr,
    input  logic [bdlp_pkg::DATA_W-1:0]   pwdata,
    input  logic                          pready,
    output int                            o_fail_count,
    output int                            o_pending
);
    import bdlp_pkg::*;

    localparam int BUTTONS = BUTTONS_DEF;
    localparam int DEPTH   = QUEUE_DEPTH_DEF;

    typedef struct packed {
        logic [CODE_W-1:0]   code;
        logic [RAW_BITS-1:0] held;
        logic [RAW_BITS-1:0] stable;
        logic [FILL_W-1:0]   fill;
        logic [DROP_W-1:0]   dropped;
    } step_result_t;

    step_result_t       expected_results [$];

    logic [15:0]        debounce_ms;
    logic [15:0]        hold_ms;
    logic               long_en;
    logic [BUTTONS-1:0] raw_lvl;
    logic [BUTTONS-1:0] stable_lvl;
    logic [BUTTONS-1:0] long_done;
    logic [31:0]        change_ms [BUTTONS];
    logic [31:0]        press_ms [BUTTONS];
    logic [CODE_W-1:0]  event_fifo [DEPTH];
    int                 fifo_head;
    int                 fifo_count;
    int                 drop_tally;
    int                 fail_tally = 0;

    task automatic push_event(input int ev);
        if (fifo_count >= DEPTH) begin
            drop_tally++;
        end else begin
            event_fifo[(fifo_head + fifo_count) % DEPTH] = ev[CODE_W-1:0];
            fifo_count++;
        end
    endtask

    task automatic debounce_step(input logic [1:0] op, input logic [RAW_BITS-1:0] raw,
                                 input logic [31:0] now, output step_result_t res);
        int          i;
        logic        lvl;
        logic        play_long;
        logic [31:0] elapsed;
        res = '0;
        drop_tally = 0;
        case (op)
            OP_INIT: begin
                for (i = 0; i < BUTTONS; i++) begin
                    raw_lvl[i]    = raw[i];
                    stable_lvl[i] = raw[i];
                    long_done[i]  = 1'b1;
                    change_ms[i]  = now;
                    press_ms[i]   = now;
                end
                res.held = raw;
            end
            OP_SAMPLE: begin
                for (i = 0; i < BUTTONS; i++) begin
                    lvl       = raw[i];
                    play_long = long_en && i == 0;
                    if (lvl != raw_lvl[i]) begin
                        // level moved: restart settle timer, nothing else this step
                        raw_lvl[i]   = lvl;
                        change_ms[i] = now;
                    end else begin
                        elapsed = now - change_ms[i];
                        if (lvl != stable_lvl[i] && elapsed >= debounce_ms) begin
                            stable_lvl[i] = lvl;
                            if (lvl) begin
                                press_ms[i]  = now;
                                long_done[i] = 1'b0;
                                if (!play_long) begin
                                    push_event(i + 1);
                                end
                            end else if (play_long && !long_done[i]) begin
                                push_event(i + 1);
                            end
                        end
                        elapsed = now - press_ms[i];
                        if (play_long && stable_lvl[i] && !long_done[i] && elapsed >= hold_ms) begin
                            long_done[i] = 1'b1;
                            push_event(BUTTONS + 1);
                        end
                    end
                end
            end
            OP_POLL: begin
                if (fifo_count > 0) begin
                    res.code  = event_fifo[fifo_head];
                    fifo_head = (fifo_head + 1) % DEPTH;
                    fifo_count--;
                end
            end
            default: ;
        endcase
        res.stable  = stable_lvl;
        res.fill    = fifo_count[FILL_W-1:0];
        res.dropped = drop_tally[DROP_W-1:0];
    endtask

    function automatic string show_result(input step_result_t r);
        return $sformatf("code %0d held %b stable %b fill %0d dropped %0d",
                         r.code, r.held, r.stable, r.fill, r.dropped);
    endfunction

    always @(posedge i_clk) begin : watch
        step_result_t got;
        step_result_t want;
        step_result_t fresh;
        int           b;
        if (!i_rst_n) begin
            expected_results.delete();
            debounce_ms = DEBOUNCE_RST;
            hold_ms     = LONG_PRESS_RST;
            long_en     = LONG_EN_RST;
            raw_lvl     = '0;
            stable_lvl  = '0;
            long_done   = '0;
            for (b = 0; b < BUTTONS; b++) begin
                change_ms[b] = '0;
                press_ms[b]  = '0;
            end
            fifo_head  = 0;
            fifo_count = 0;
        end else begin
            if (i_out_valid && i_out_ready) begin
                got.code    = i_event_code;
                got.held    = i_held_at_init;
                got.stable  = i_stable_mask;
                got.fill    = i_queue_fill;
                got.dropped = i_dropped_now;
                if (expected_results.size() == 0) begin
                    fail_tally++;
                    $display("%0t: unexpected result, expected none, got %s",
                             $time, show_result(got));
                end else begin
                    want = expected_results.pop_front();
                    if (got !== want) begin
                        fail_tally++;
                        $display("%0t: result mismatch, expected %s, got %s",
                                 $time, show_result(want), show_result(got));
                    end
                end
            end
            if (i_in_valid && i_in_ready) begin
                debounce_step(i_operation, i_raw_buttons, i_now_ms, fresh);
                expected_results.push_back(fresh);
            end
            if (psel && penable && pwrite && pready) begin
                case (paddr[3:2])
                    REG_DEBOUNCE:   debounce_ms = pwdata[15:0];
                    REG_LONG_PRESS: hold_ms = pwdata[15:0];
                    REG_LONG_EN:    long_en = pwdata[0];
                    default: ;
                endcase
            end
        end
        o_fail_count <= fail_tally;
        o_pending    <= expected_results.size();
    end

endmodule

@@ tb/button_debounce_long_press_queue_tb.sv @@
// Testbench top: clock, reset, stimulus and verdict for the button debounce long press queue.
`timescale 1ns / 1ps

module button_debounce_long_press_queue_tb;
    import bdlp_pkg::*;

    localparam logic [1:0] OP_UNUSED      = 2'd3;
    localparam int         WATCHDOG_LIMIT = 400;
    localparam int         PHASE_ITEMS    = 132;

    logic                i_clk       = 1'b0;
    logic                i_rst_n     = 1'b0;
    logic                in_valid    = 1'b0;
    logic                in_ready;
    logic [1:0]          operation   = OP_POLL;
    logic [RAW_BITS-1:0] raw_buttons = '0;
    logic [31:0]         now_ms      = '0;
    logic                out_valid;
    logic                out_ready   = 1'b0;
    logic [CODE_W-1:0]   event_code;
    logic [RAW_BITS-1:0] held_at_init;
    logic [RAW_BITS-1:0] stable_mask;
    logic [FILL_W-1:0]   queue_fill;
    logic [DROP_W-1:0]   dropped_now;
    logic                psel        = 1'b0;
    logic                penable     = 1'b0;
    logic                pwrite      = 1'b0;
    logic [ADDR_W-1:0]   paddr       = '0;
    logic [DATA_W-1:0]   pwdata      = '0;
    logic [DATA_W-1:0]   prdata;
    logic                pready;

    int                  fail_count;
    int                  pending;
    int                  quiet_cycles = 0;
    int                  idle_odds    = 0;
    int                  stall_left   = 0;
    int                  cur_debounce = DEBOUNCE_RST;
    int                  cur_hold     = LONG_PRESS_RST;
    logic [RAW_BITS-1:0] held_keys    = '0;
    logic [31:0]         ms_clock     = '0;

    always #6 i_clk = ~i_clk;

    button_debounce_long_press_queue dut (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_in_valid     (in_valid),
        .o_in_ready     (in_ready),
        .i_operation    (operation),
        .i_raw_buttons  (raw_buttons),
        .i_now_ms       (now_ms),
        .o_out_valid    (out_valid),
        .i_out_ready    (out_ready),
        .o_event_code   (event_code),
        .o_held_at_init (held_at_init),
        .o_stable_mask  (stable_mask),
        .o_queue_fill   (queue_fill),
        .o_dropped_now  (dropped_now),
        .psel           (psel),
        .penable        (penable),
        .pwrite         (pwrite),
        .paddr          (paddr),
        .pwdata         (pwdata),
        .prdata         (prdata),
        .pready         (pready)
    );

    bdlp_event_checker event_check (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_in_valid     (in_valid),
        .i_in_ready     (in_ready),
        .i_operation    (operation),
        .i_raw_buttons  (raw_buttons),
        .i_now_ms       (now_ms),
        .i_out_valid    (out_valid),
        .i_out_ready    (out_ready),
        .i_event_code   (event_code),
        .i_held_at_init (held_at_init),
        .i_stable_mask  (stable_mask),
        .i_queue_fill   (queue_fill),
        .i_dropped_now  (dropped_now),
        .psel           (psel),
        .penable        (penable),
        .pwrite         (pwrite),
        .paddr          (paddr),
        .pwdata         (pwdata),
        .pready         (pready),
        .o_fail_count   (fail_count),
        .o_pending      (pending)
    );

    // receiver back-pressure in bursts
    always @(negedge i_clk) begin
        if (stall_left > 0) begin
            stall_left--;
            out_ready <= 1'b0;
        end else if (idle_odds != 0 && $urandom_range(0, 2 * idle_odds) == 0) begin
            stall_left = $urandom_range(0, 10);
            out_ready <= 1'b0;
        end else begin
            out_ready <= 1'b1;
        end
    end

    always @(posedge i_clk) begin
        if (!i_rst_n || (in_valid && in_ready) || (out_valid && out_ready)
                || (psel && penable && pwrite && pready)) begin
            quiet_cycles <= 0;
        end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
            $display("simulation failed");
            $finish;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

    task automatic send_item(input logic [1:0] op, input logic [RAW_BITS-1:0] raw,
                             input logic [31:0] now);
        int gap;
        if (idle_odds != 0 && $urandom_range(1, idle_odds) == 1) begin
            gap = $urandom_range(1, 11);
            @(negedge i_clk);
            in_valid <= 1'b0;
            repeat (gap - 1) @(negedge i_clk);
        end
        @(negedge i_clk);
        in_valid    <= 1'b1;
        operation   <= op;
        raw_buttons <= raw;
        now_ms      <= now;
        do @(posedge i_clk); while (!in_ready);
    endtask

    task automatic drain();
        @(negedge i_clk);
        in_valid <= 1'b0;
        while (pending != 0) begin
            @(posedge i_clk);
        end
    endtask

    task automatic write_reg(input logic [1:0] idx, input logic [DATA_W-1:0] value);
        @(negedge i_clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {idx, 2'b00};
        pwdata  <= value;
        @(negedge i_clk);
        penable <= 1'b1;
        do @(posedge i_clk); while (!pready);
        @(negedge i_clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
    endtask

    // time advance shaped around the current windows
    function automatic logic [31:0] next_gap_ms();
        int pick;
        pick = $urandom_range(0, 99);
        if (pick < 15) return 0;
        if (pick < 50) return $urandom_range(0, cur_debounce / 4 + 1);
        if (pick < 82) return cur_debounce + $urandom_range(0, 2) - 1;
        if (pick < 97) return cur_hold / 2 + $urandom_range(0, cur_hold / 2 + 2);
        return $urandom;
    endfunction

    task automatic run_phase(input int debounce, input int hold, input logic long_on,
                             input int odds, input int poll_pct);
        int                  n;
        int                  pick;
        int                  flip;
        logic [RAW_BITS-1:0] raw;
        write_reg(REG_DEBOUNCE, debounce);
        write_reg(REG_LONG_PRESS, hold);
        write_reg(REG_LONG_EN, {31'b0, long_on});
        cur_debounce = debounce;
        cur_hold     = hold;
        idle_odds    = odds;
        if ($urandom_range(0, 1) == 0) begin
            ms_clock = $urandom;
        end else begin
            ms_clock = 32'hFFFF_FFFF - $urandom_range(0, 3000);
        end
        held_keys = RAW_BITS'($urandom);
        send_item(OP_INIT, held_keys, ms_clock);
        for (n = 1; n < PHASE_ITEMS; n++) begin
            pick = $urandom_range(0, 99);
            if (pick < 3) begin
                held_keys = RAW_BITS'($urandom);
                ms_clock  = ms_clock + next_gap_ms();
                send_item(OP_INIT, held_keys, ms_clock);
            end else if (pick < 5) begin
                send_item(OP_UNUSED, RAW_BITS'($urandom), $urandom);
            end else if (pick < 5 + poll_pct) begin
                send_item(OP_POLL, RAW_BITS'($urandom), $urandom);
            end else if (pick < 9 + poll_pct) begin
                send_item(OP_SAMPLE, RAW_BITS'($urandom), $urandom);
            end else begin
                if ($urandom_range(0, 3) == 0) begin
                    flip            = $urandom_range(0, RAW_BITS - 1);
                    held_keys[flip] = ~held_keys[flip];
                end
                raw = held_keys;
                if ($urandom_range(0, 9) == 0) begin
                    flip      = $urandom_range(0, RAW_BITS - 1);
                    raw[flip] = ~raw[flip];
                end
                ms_clock = ms_clock + next_gap_ms();
                send_item(OP_SAMPLE, raw, ms_clock);
            end
        end
        drain();
    endtask

    initial begin
        logic [31:0] t;
        repeat (9) @(negedge i_clk);
        i_rst_n <= 1'b1;
        idle_odds = 3;

        // reset config: window 20, hold 800, long press on
        send_item(OP_UNUSED, 5'h1F, 32'hFFFF_FFFF);
        t = 32'hFFFF_FFF0;
        send_item(OP_INIT, 5'h1F, t);
        send_item(OP_SAMPLE, 5'h00, t + 1);
        send_item(OP_SAMPLE, 5'h00, 32'h10);
        send_item(OP_SAMPLE, 5'h1F, 32'h20);
        t = 32'h34;
        send_item(OP_SAMPLE, 5'h1F, t);
        send_item(OP_SAMPLE, 5'h1F, t + 799);
        send_item(OP_SAMPLE, 5'h1F, t + 800);
        t = t + 801;
        send_item(OP_SAMPLE, 5'h1E, t);
        send_item(OP_SAMPLE, 5'h1E, t + 19);
        send_item(OP_SAMPLE, 5'h1E, t + 20);
        t = t + 40;
        send_item(OP_SAMPLE, 5'h1F, t);
        send_item(OP_SAMPLE, 5'h1F, t + 20);
        send_item(OP_SAMPLE, 5'h1E, t + 25);
        send_item(OP_SAMPLE, 5'h1E, t + 45);
        t = t + 60;
        send_item(OP_SAMPLE, 5'h00, t);
        send_item(OP_SAMPLE, 5'h00, t + 20);
        send_item(OP_SAMPLE, 5'h1E, t + 30);
        send_item(OP_SAMPLE, 5'h1E, t + 50);
        repeat (9) send_item(OP_POLL, 5'h00, t);
        drain();

        run_phase(3, 40, 1'b1, 4, 30);
        run_phase(0, 0, 1'b1, 3, 15);
        run_phase(0, 65535, 1'b0, 6, 20);
        run_phase(65535, 65535, 1'b1, 5, 35);
        run_phase(5, 12, 1'b0, 2, 25);
        run_phase($urandom_range(0, 40), $urandom_range(0, 300),
                  1'($urandom_range(0, 1)), 4, 30);
        run_phase(2, 25, 1'b1, 0, 30);

        repeat (16) @(posedge i_clk);
        if (fail_count == 0 && pending == 0) begin
            $display("simulation ok");
        end else begin
            $display("simulation failed");
        end
        $finish;
    end

endmodule
